// ===== hdl/cdm_pkg.sv =====
`timescale 1ns / 1ps
// cdm_pkg: shared constants, types and helpers of the curvature drive mixer
// holds the queue entry type, the register codes and the curve table builder
// no dependencies
package cdm_pkg;

	localparam int FRAC_BITS     = 14;
	localparam int ONE           = 1 << FRAC_BITS;
	localparam int CURVE_ENTRIES = 1024;

	localparam int IN_W     = 16;
	localparam int OUT_W    = 18;
	localparam int MAG_W    = IN_W + 1;
	localparam int DIFF_W   = IN_W + 1;
	localparam int ACC_W    = 20;
	localparam int IDX_W    = $clog2(CURVE_ENTRIES + 1);
	localparam int CURVE_W  = FRAC_BITS + 1;
	localparam int SCALED_W = FRAC_BITS + IDX_W + 2;

	localparam int DB_W    = 15;
	localparam int SLEW_W  = 15;
	localparam int GAIN_W  = 17;
	localparam int SENS_W  = 16;
	localparam int CFG_W   = 17;
	localparam int CFG_IDX_W = 2;

	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	localparam int OUT_MAX = 8 * ONE - 1;
	localparam int OUT_MIN = -8 * ONE;

	localparam longint PI4_Q30   = 64'sd843314857;
	localparam longint SQRT2_Q30 = 64'sd1518500250;

	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd3;

	localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd328;
	localparam logic [SLEW_W-1:0] SLEW_RST     = 15'd328;
	localparam logic [GAIN_W-1:0] GAIN_RST     = 17'd49152;
	localparam logic [SENS_W-1:0] SENS_RST     = 16'd16384;

	typedef struct packed {
		logic [DB_W-1:0]   deadband;
		logic [SLEW_W-1:0] slew_step;
	} cdm_limit_t;

	typedef struct packed {
		logic [GAIN_W-1:0] inertia_gain;
		logic [SENS_W-1:0] turn_sensitivity;
	} cdm_gain_t;

	typedef struct packed {
		logic signed [IN_W-1:0]   lin;
		logic [IDX_W-1:0]         idx;
		logic                     turn_neg;
		logic signed [DIFF_W-1:0] diff;
		logic                     in_place;
	} cdm_entry_t;

	typedef logic [CURVE_W-1:0] curve_tbl_t [CURVE_ENTRIES+1];

	// curve index of a magnitude, clamped at one
	function automatic logic [IDX_W-1:0] curve_idx(input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0]    m;
		logic [SCALED_W-1:0] scaled;
		logic [SCALED_W-1:0] idx;
		m = (mag > MAG_W'(ONE)) ? MAG_W'(ONE) : mag;
		scaled = SCALED_W'(m) * SCALED_W'(CURVE_ENTRIES) + SCALED_W'(ONE / 2);
		idx = scaled >> FRAC_BITS;
		if (idx > SCALED_W'(CURVE_ENTRIES)) begin
			idx = SCALED_W'(CURVE_ENTRIES);
		end
		return idx[IDX_W-1:0];
	endfunction

	// sine curve over an eighth turn, normalised to one at the end, q30 series
	function automatic curve_tbl_t build_curve();
		curve_tbl_t tbl;
		longint a;
		longint a2;
		longint term;
		longint s;
		longint r;
		int k;
		for (k = 0; k <= CURVE_ENTRIES; k++) begin
			a = PI4_Q30 * longint'(k) / CURVE_ENTRIES;
			a2 = (a * a) >>> 30;
			term = a;
			s = a;
			term = ((term * a2) >>> 30) / 6;
			s = s - term;
			term = ((term * a2) >>> 30) / 20;
			s = s + term;
			term = ((term * a2) >>> 30) / 42;
			s = s - term;
			term = ((term * a2) >>> 30) / 72;
			s = s + term;
			term = ((term * a2) >>> 30) / 110;
			s = s - term;
			term = ((term * a2) >>> 30) / 156;
			s = s + term;
			term = ((term * a2) >>> 30) / 210;
			s = s - term;
			r = (s * SQRT2_Q30) >>> 30;
			r = (r + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
			tbl[k] = r[CURVE_W-1:0];
		end
		return tbl;
	endfunction

endpackage

// ===== hdl/curvature_drive_mixer.sv =====
`timescale 1ns / 1ps
// curvature_drive_mixer: top level with configuration registers
// uses cdm_pkg, cdm_front, cdm_queue and cdm_back
//
// Input channel: throttle and turn in q1.14, in_valid / in_stall; a
// transaction is taken at a clock edge with in_valid high and in_stall low.
// Output channel: left_drive, right_drive (q3.14, saturated) and in_place,
// out_valid / out_stall, held in an output register.
// Configuration: cfg_we, cfg_index and cfg_data, to be written by the user
// only while idle; the block does not enforce it. The front classifies
// each transaction in its accept cycle and writes it to a two-entry queue.
// The back sequencer works one transaction at a time with two curve rom
// reads and one shared multiplier, stepping through idle, look2, shape,
// scale and mix; a turn in place skips mix and is done after scale.
// Reset clears the previous limited throttle, previous turn and accumulator
// and loads the default register values. While the receiver stalls the
// result holds, the back finishes the next transaction and waits, and once
// the queue is full in_stall rises.
module curvature_drive_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [cdm_pkg::IN_W-1:0]      throttle,
	input  logic signed [cdm_pkg::IN_W-1:0]      turn,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [cdm_pkg::OUT_W-1:0]     left_drive,
	output logic signed [cdm_pkg::OUT_W-1:0]     right_drive,
	output logic                                 in_place,
	input  logic                                 cfg_we,
	input  logic [cdm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cdm_pkg::CFG_W-1:0]            cfg_data
);
	import cdm_pkg::*;

	cdm_limit_t limits_q;
	cdm_gain_t  gains_q;
	cdm_entry_t wr_entry;
	cdm_entry_t head;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.deadband        <= DEADBAND_RST;
			limits_q.slew_step       <= SLEW_RST;
			gains_q.inertia_gain     <= GAIN_RST;
			gains_q.turn_sensitivity <= SENS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEADBAND:    limits_q.deadband        <= cfg_data[DB_W-1:0];
				REG_SLEW_STEP:   limits_q.slew_step       <= cfg_data[SLEW_W-1:0];
				REG_INERTIA:     gains_q.inertia_gain     <= cfg_data[GAIN_W-1:0];
				REG_SENSITIVITY: gains_q.turn_sensitivity <= cfg_data[SENS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	cdm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.throttle (throttle),
		.turn     (turn),
		.limits   (limits_q),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	cdm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	cdm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains_q),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.in_place    (in_place)
	);

endmodule

// ===== hdl/cdm_front.sv =====
`timescale 1ns / 1ps
// cdm_front: accepts joystick transactions, picks turn in place or slew limit
// keeps the previous limited throttle and turn; depends on cdm_pkg
module cdm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [cdm_pkg::IN_W-1:0] throttle,
	input  logic signed [cdm_pkg::IN_W-1:0] turn,
	input  cdm_pkg::cdm_limit_t             limits,
	input  logic                            q_full,
	output logic                            push,
	output cdm_pkg::cdm_entry_t             entry
);
	import cdm_pkg::*;

	localparam int D_W = IN_W + 2;

	logic signed [IN_W-1:0]  last_linear_q;
	logic signed [IN_W-1:0]  last_turn_q;
	logic signed [MAG_W-1:0] thr_ext;
	logic signed [MAG_W-1:0] turn_ext;
	logic [MAG_W-1:0]        athr;
	logic [MAG_W-1:0]        aturn;
	logic [MAG_W-1:0]        db_ext;
	logic                    in_place;
	logic signed [D_W-1:0]   delta;
	logic signed [D_W-1:0]   last_ext;
	logic signed [D_W-1:0]   step_up;
	logic signed [D_W-1:0]   step_dn;
	logic signed [D_W-1:0]   lin_up;
	logic signed [D_W-1:0]   lin_dn;
	logic signed [IN_W-1:0]  lin;

	assign thr_ext  = MAG_W'(throttle);
	assign turn_ext = MAG_W'(turn);
	assign athr     = thr_ext[MAG_W-1] ? MAG_W'(-thr_ext) : MAG_W'(thr_ext);
	assign aturn    = turn_ext[MAG_W-1] ? MAG_W'(-turn_ext) : MAG_W'(turn_ext);
	assign db_ext   = MAG_W'(limits.deadband);
	assign in_place = (athr < db_ext) && (aturn > db_ext);

	assign last_ext = D_W'(last_linear_q);
	assign step_up  = D_W'(limits.slew_step);
	assign step_dn  = D_W'({limits.slew_step, 1'b0});
	assign delta    = D_W'(throttle) - last_ext;
	assign lin_up   = last_ext + step_up;
	assign lin_dn   = last_ext - step_dn;

	always_comb begin
		if (in_place) begin
			lin = '0;
		end else if (delta > step_up) begin
			lin = lin_up[IN_W-1:0];
		end else if (delta < -step_dn) begin
			lin = lin_dn[IN_W-1:0];
		end else begin
			lin = throttle;
		end
	end

	assign in_stall       = q_full;
	assign push           = in_valid && !q_full;
	assign entry.lin      = lin;
	assign entry.idx      = curve_idx(aturn);
	assign entry.turn_neg = turn[IN_W-1];
	assign entry.diff     = DIFF_W'(turn) - DIFF_W'(last_turn_q);
	assign entry.in_place = in_place;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_linear_q <= '0;
			last_turn_q   <= '0;
		end else if (push) begin
			last_linear_q <= lin;
			last_turn_q   <= turn;
		end
	end

endmodule

// ===== hdl/cdm_queue.sv =====
`timescale 1ns / 1ps
// cdm_queue: short fifo of classified transactions between front and back
// depends on cdm_pkg
module cdm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cdm_pkg::cdm_entry_t wr_entry,
	input  logic                pop,
	output cdm_pkg::cdm_entry_t head,
	output logic                full,
	output logic                empty
);
	import cdm_pkg::*;

	cdm_entry_t         slots_q [Q_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full  = (count_q == QCNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/cdm_back.sv =====
`timescale 1ns / 1ps
// cdm_back: sequencer with curve rom and one shared multiplier
// owns the inertia accumulator and the output register; depends on cdm_pkg
module cdm_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cdm_pkg::cdm_gain_t               gains,
	input  cdm_pkg::cdm_entry_t              head,
	input  logic                             q_empty,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [cdm_pkg::OUT_W-1:0] left_drive,
	output logic signed [cdm_pkg::OUT_W-1:0] right_drive,
	output logic                             in_place
);
	import cdm_pkg::*;

	localparam int MA_W      = 22;
	localparam int MB_W      = 18;
	localparam int PROD_W    = MA_W + MB_W;
	localparam int SHR_W     = PROD_W - FRAC_BITS;
	localparam int MIX_W     = SHR_W + 1;
	localparam int ACC_SUM_W = ACC_W + 2;

	localparam logic signed [ACC_W-1:0]     ACC_ONE = ACC_W'(ONE);
	localparam logic signed [ACC_SUM_W-1:0] ACC_HI  = ACC_SUM_W'((1 << (ACC_W - 1)) - 1);
	localparam logic signed [ACC_SUM_W-1:0] ACC_LO  = -ACC_SUM_W'(1 << (ACC_W - 1));
	localparam logic signed [MIX_W-1:0]     MIX_HI  = MIX_W'(OUT_MAX);
	localparam logic signed [MIX_W-1:0]     MIX_LO  = MIX_W'(OUT_MIN);

	localparam curve_tbl_t CURVE_ROM = build_curve();

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK2,
		S_SHAPE,
		S_SCALE,
		S_MIX
	} state_t;

	state_t                     state_q;
	cdm_entry_t                 item_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [CURVE_W-1:0]         rom_q;
	logic [IDX_W-1:0]           rom_addr;
	logic                       out_valid_q;
	logic signed [OUT_W-1:0]    left_q;
	logic signed [OUT_W-1:0]    right_q;
	logic                       in_place_q;

	logic signed [MA_W-1:0]      mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]    mul_p;
	logic signed [SHR_W-1:0]     shr_out;
	logic signed [ACC_SUM_W-1:0] acc_sum;
	logic signed [ACC_W-1:0]     acc_sat;
	logic signed [ACC_W-1:0]     acc_decay;
	logic signed [IN_W-1:0]      rom_val;
	logic signed [IN_W-1:0]      r_val;
	logic signed [MA_W-1:0]      r_plus_acc;
	logic signed [MAG_W-1:0]     lin_ext;
	logic [MAG_W-1:0]            alin;
	logic signed [MIX_W-1:0]     sq_ext;
	logic signed [MIX_W-1:0]     mix_l;
	logic signed [MIX_W-1:0]     mix_r;
	logic                        out_free;
	logic                        out_load;

	// product shifted down, truncated toward zero
	function automatic logic signed [SHR_W-1:0] shr_tz(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] b;
		bias = v[PROD_W-1] ? PROD_W'(ONE - 1) : '0;
		b = v + bias;
		return b[PROD_W-1:FRAC_BITS];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] c;
		c = (v > MIX_HI) ? MIX_HI : ((v < MIX_LO) ? MIX_LO : v);
		return c[OUT_W-1:0];
	endfunction

	assign shr_out = shr_tz(prod_q);

	assign acc_sum = ACC_SUM_W'(acc_q) + ACC_SUM_W'(shr_out);
	always_comb begin
		if (acc_sum > ACC_HI) begin
			acc_sat = ACC_HI[ACC_W-1:0];
		end else if (acc_sum < ACC_LO) begin
			acc_sat = ACC_LO[ACC_W-1:0];
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	always_comb begin
		if (acc_q > ACC_ONE) begin
			acc_decay = acc_q - ACC_ONE;
		end else if (acc_q < -ACC_ONE) begin
			acc_decay = acc_q + ACC_ONE;
		end else begin
			acc_decay = '0;
		end
	end

	assign rom_val    = IN_W'(rom_q);
	assign r_val      = item_q.turn_neg ? -rom_val : rom_val;
	assign r_plus_acc = MA_W'(r_val) + MA_W'(acc_q);
	assign lin_ext    = MAG_W'(item_q.lin);
	assign alin       = lin_ext[MAG_W-1] ? MAG_W'(-lin_ext) : MAG_W'(lin_ext);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = MA_W'(head.diff);
				mul_b = MB_W'(gains.inertia_gain);
			end
			S_SHAPE: begin
				if (item_q.in_place) begin
					mul_a = MA_W'(r_val);
					mul_b = MB_W'(rom_q);
				end else begin
					mul_a = r_plus_acc;
					mul_b = MB_W'(alin);
				end
			end
			S_SCALE: begin
				mul_a = MA_W'(shr_out);
				mul_b = MB_W'(gains.turn_sensitivity);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign rom_addr = (state_q == S_IDLE) ? head.idx : curve_idx(MAG_W'(rom_q));

	always_ff @(posedge clk) begin
		rom_q <= CURVE_ROM[rom_addr];
	end

	assign sq_ext   = MIX_W'(shr_out);
	assign mix_l    = MIX_W'(item_q.lin) + MIX_W'(shr_out);
	assign mix_r    = MIX_W'(item_q.lin) - MIX_W'(shr_out);
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_load = out_free && ((state_q == S_MIX) ||
		(state_q == S_SCALE && item_q.in_place));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						item_q  <= head;
						prod_q  <= mul_p;
						state_q <= S_LOOK2;
					end
				end
				S_LOOK2: begin
					if (!item_q.in_place) begin
						acc_q <= acc_sat;
					end
					state_q <= S_SHAPE;
				end
				S_SHAPE: begin
					prod_q  <= mul_p;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (item_q.in_place) begin
						if (out_free) begin
							left_q      <= sat_out(sq_ext);
							right_q     <= sat_out(-sq_ext);
							in_place_q  <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						prod_q  <= mul_p;
						acc_q   <= acc_decay;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					if (out_free) begin
						left_q      <= sat_out(mix_l);
						right_q     <= sat_out(mix_r);
						in_place_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign in_place    = in_place_q;

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == S_LOOK2))
		else $error("pop did not start the sequence");

	a_idle_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && q_empty) |=> (state_q == S_IDLE))
		else $error("sequencer left idle without a transaction");

	a_acc_in_place: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK2 && item_q.in_place) |=> $stable(acc_q))
		else $error("accumulator changed on turn in place");

	a_spin_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && in_place_q) |-> (right_q == -left_q))
		else $error("turn in place outputs not mirrored");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> !out_stall)
		else $error("held result overwritten");

endmodule

// ===== dv/tb_curvature_drive_mixer.sv =====
`timescale 1ns / 1ps
// tb_curvature_drive_mixer: self-checking testbench of the curvature drive mixer
// drives throttle/turn transactions, compares each result with a local model of
// mixer state or a directed row's drive; depends on cdm_pkg, curvature_drive_mixer
module tb_curvature_drive_mixer;

	localparam int     WATCHDOG_LIMIT  = 3000;
	localparam int     ITEMS_PER_PHASE = 265;
	localparam int     NUM_PHASES      = 6;
	localparam int     FB              = cdm_pkg::FRAC_BITS;
	localparam int     LUT_LAST        = cdm_pkg::CURVE_ENTRIES;
	localparam longint UNIT            = longint'(1) << FB;
	localparam longint QUARTER_PI_Q30  = 64'sd843314857;
	localparam longint ROOT2_Q30       = 64'sd1518500250;
	localparam longint ACC_HI          = 32 * UNIT - 1;
	localparam longint ACC_LO          = -32 * UNIT;
	localparam longint DRIVE_HI        = 8 * UNIT - 1;
	localparam longint DRIVE_LO        = -8 * UNIT;

	typedef struct {
		logic signed [cdm_pkg::OUT_W-1:0] left;
		logic signed [cdm_pkg::OUT_W-1:0] right;
		logic                             pivot;
	} drive_t;

	typedef struct {
		logic signed [cdm_pkg::IN_W-1:0] thr;
		logic signed [cdm_pkg::IN_W-1:0] trn;
		bit                              known;
		drive_t                          drv;
	} stim_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic signed [cdm_pkg::IN_W-1:0]    throttle = '0;
	logic signed [cdm_pkg::IN_W-1:0]    turn = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic signed [cdm_pkg::OUT_W-1:0]   left_drive;
	logic signed [cdm_pkg::OUT_W-1:0]   right_drive;
	logic                               in_place;
	logic                               cfg_we = 1'b0;
	logic [cdm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [cdm_pkg::CFG_W-1:0]          cfg_data = '0;

	// model state and register copies
	longint sine_lut [0:LUT_LAST];
	longint held_turn;
	longint held_lin;
	longint inertia_sum;
	longint db_reg;
	longint slew_reg;
	longint gain_reg;
	longint sens_reg;

	drive_t pending_drive [$];
	bit     row_known;
	drive_t row_drive;
	logic   took_in = 1'b0;
	int     idle_cycles = 0;
	int     mismatches = 0;
	int     results_seen = 0;
	int     sent_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     walk_thr = 0;
	int     walk_turn = 0;

	curvature_drive_mixer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.throttle    (throttle),
		.turn        (turn),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.in_place    (in_place),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void fill_sine_lut();
		longint ang;
		longint ang_sq;
		longint term;
		longint series;
		longint scaled;
		int     k;
		int     n;
		for (k = 0; k <= LUT_LAST; k++) begin
			ang = QUARTER_PI_Q30 * k / LUT_LAST;
			ang_sq = (ang * ang) >>> 30;
			term = ang;
			series = ang;
			for (n = 1; n <= 7; n++) begin
				term = ((term * ang_sq) >>> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					series = series - term;
				end else begin
					series = series + term;
				end
			end
			scaled = (series * ROOT2_Q30) >>> 30;
			sine_lut[k] = (scaled + (longint'(1) << (29 - FB))) >>> (30 - FB);
		end
	endfunction

	function automatic longint trunc_q(input longint v);
		return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint shape_turn(input longint x);
		longint mag;
		longint idx;
		mag = (x < 0) ? -x : x;
		if (mag > UNIT) begin
			mag = UNIT;
		end
		idx = (mag * LUT_LAST + UNIT / 2) >>> FB;
		if (idx > LUT_LAST) begin
			idx = LUT_LAST;
		end
		return (x < 0) ? -sine_lut[idx] : sine_lut[idx];
	endfunction

	// next drive command, advancing the mixer state
	function automatic drive_t mix_predict(input logic signed [cdm_pkg::IN_W-1:0] thr_in,
			input logic signed [cdm_pkg::IN_W-1:0] turn_in);
		longint thr;
		longint trn;
		longint lin;
		longint shaped;
		longint sq;
		longint power;
		longint alin;
		longint blend;
		longint ang;
		longint l;
		longint r;
		logic   pivot;
		drive_t res;
		thr = thr_in;
		trn = turn_in;
		lin = thr;
		pivot = 1'b0;
		if (((thr < 0) ? -thr : thr) < db_reg && ((trn < 0) ? -trn : trn) > db_reg) begin
			lin = 0;
			pivot = 1'b1;
		end else if (thr - held_lin > slew_reg) begin
			lin = held_lin + slew_reg;
		end else if (thr - held_lin < -2 * slew_reg) begin
			lin = held_lin - 2 * slew_reg;
		end
		shaped = shape_turn(shape_turn(trn));
		if (pivot) begin
			sq = trunc_q(shaped * ((shaped < 0) ? -shaped : shaped));
			l = clip(sq, DRIVE_LO, DRIVE_HI);
			r = clip(-sq, DRIVE_LO, DRIVE_HI);
		end else begin
			power = trunc_q((trn - held_turn) * gain_reg);
			alin = (lin < 0) ? -lin : lin;
			inertia_sum = clip(inertia_sum + power, ACC_LO, ACC_HI);
			blend = trunc_q(alin * (shaped + inertia_sum));
			ang = trunc_q(blend * sens_reg);
			l = clip(lin + ang, DRIVE_LO, DRIVE_HI);
			r = clip(lin - ang, DRIVE_LO, DRIVE_HI);
			if (inertia_sum > UNIT) begin
				inertia_sum = inertia_sum - UNIT;
			end else if (inertia_sum < -UNIT) begin
				inertia_sum = inertia_sum + UNIT;
			end else begin
				inertia_sum = 0;
			end
		end
		held_turn = trn;
		held_lin = lin;
		res.left = l[cdm_pkg::OUT_W-1:0];
		res.right = r[cdm_pkg::OUT_W-1:0];
		res.pivot = pivot;
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("%0t mismatch: %s", $time, msg);
		end
	endtask

	// result checking and model update at the clock edge
	always @(posedge clk) begin
		drive_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_drive.size() == 0) begin
					flag_mismatch($sformatf("result with none pending: %0d %0d %0b",
						left_drive, right_drive, in_place));
				end else begin
					want = pending_drive.pop_front();
					results_seen++;
					if (left_drive !== want.left) begin
						flag_mismatch($sformatf("left_drive %0d, want %0d", left_drive, want.left));
					end
					if (right_drive !== want.right) begin
						flag_mismatch($sformatf("right_drive %0d, want %0d",
							right_drive, want.right));
					end
					if (in_place !== want.pivot) begin
						flag_mismatch($sformatf("in_place %0b, want %0b", in_place, want.pivot));
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = mix_predict(throttle, turn);
				if (row_known) begin
					want = row_drive;
				end
				pending_drive.push_back(want);
			end
			took_in <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
		end
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_sample(input logic signed [cdm_pkg::IN_W-1:0] thr,
			input logic signed [cdm_pkg::IN_W-1:0] trn, input bit known, input drive_t drv);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		throttle <= thr;
		turn <= trn;
		in_valid <= 1'b1;
		row_known = known;
		row_drive = drv;
		do begin
			@(negedge clk);
		end while (!took_in);
		sent_count++;
	endtask

	task automatic program_regs(input int db, input int sl, input int gn, input int sn);
		cfg_we <= 1'b1;
		cfg_index <= cdm_pkg::REG_DEADBAND;
		cfg_data <= cdm_pkg::CFG_W'(db);
		@(negedge clk);
		cfg_index <= cdm_pkg::REG_SLEW_STEP;
		cfg_data <= cdm_pkg::CFG_W'(sl);
		@(negedge clk);
		cfg_index <= cdm_pkg::REG_INERTIA;
		cfg_data <= cdm_pkg::CFG_W'(gn);
		@(negedge clk);
		cfg_index <= cdm_pkg::REG_SENSITIVITY;
		cfg_data <= cdm_pkg::CFG_W'(sn);
		@(negedge clk);
		cfg_we <= 1'b0;
		db_reg = db;
		slew_reg = sl;
		gain_reg = gn;
		sens_reg = sn;
	endtask

	function automatic int clamp_unit(input int v);
		return (v > 16384) ? 16384 : ((v < -16384) ? -16384 : v);
	endfunction

	// smooth joystick motion, with uniform pairs, deadband probing, extremes and noise
	task automatic pick_pair(output logic signed [cdm_pkg::IN_W-1:0] thr,
			output logic signed [cdm_pkg::IN_W-1:0] trn);
		int kind;
		int a;
		int b;
		int db;
		kind = $urandom_range(99);
		db = int'(db_reg);
		if (kind < 45) begin
			a = clamp_unit(walk_thr + int'($urandom_range(2400)) - 1200);
			b = clamp_unit(walk_turn + int'($urandom_range(4000)) - 2000);
		end else if (kind < 60) begin
			a = int'($urandom_range(32768)) - 16384;
			b = int'($urandom_range(32768)) - 16384;
		end else if (kind < 75) begin
			a = int'($urandom_range(2 * db)) - db;
			if ($urandom_range(1)) begin
				b = db + int'($urandom_range(4)) - 2;
			end else begin
				b = int'($urandom_range(32768)) - 16384;
			end
			if ($urandom_range(1)) begin
				b = -b;
			end
		end else if (kind < 90) begin
			a = (int'($urandom_range(2)) - 1) * 16384;
			b = (int'($urandom_range(2)) - 1) * 16384;
		end else begin
			a = int'($signed(16'($urandom)));
			b = int'($signed(16'($urandom)));
		end
		thr = a[cdm_pkg::IN_W-1:0];
		trn = b[cdm_pkg::IN_W-1:0];
		walk_thr = clamp_unit(a);
		walk_turn = clamp_unit(b);
	endtask

	initial begin
		stim_row_t                       directed_rows [19];
		logic signed [cdm_pkg::IN_W-1:0] thr;
		logic signed [cdm_pkg::IN_W-1:0] trn;
		drive_t                          none;
		int                              phase;
		int                              i;
		none = '{'0, '0, 1'b0};
		directed_rows = '{
			'{16'sd0, 16'sd0, 1'b1, '{18'sd0, 18'sd0, 1'b0}},
			'{16'sd0, 16'sd16384, 1'b1, '{18'sd16384, -18'sd16384, 1'b1}},
			'{16'sd0, -16'sd16384, 1'b1, '{-18'sd16384, 18'sd16384, 1'b1}},
			'{16'sd327, 16'sd329, 1'b0, '{'0, '0, 1'b0}},
			'{-16'sd327, -16'sd329, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd328, 16'sd16384, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd0, 16'sd328, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd16384, 16'sd0, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd16384, 16'sd8192, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd16384, -16'sd8192, 1'b0, '{'0, '0, 1'b0}},
			'{-16'sd16384, 16'sd16384, 1'b0, '{'0, '0, 1'b0}},
			'{-16'sd16384, -16'sd16384, 1'b0, '{'0, '0, 1'b0}},
			'{16'sh7FFF, 16'sh8000, 1'b0, '{'0, '0, 1'b0}},
			'{16'sh8000, 16'sh7FFF, 1'b0, '{'0, '0, 1'b0}},
			'{16'sh8000, 16'sh8000, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd1, -16'sd1, 1'b0, '{'0, '0, 1'b0}},
			'{-16'sd1, 16'sd1, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd16384, 16'sd16384, 1'b0, '{'0, '0, 1'b0}},
			'{16'sd0, 16'sd0, 1'b0, '{'0, '0, 1'b0}}
		};
		fill_sine_lut();
		held_turn = 0;
		held_lin = 0;
		inertia_sum = 0;
		db_reg = 328;
		slew_reg = 328;
		gain_reg = 49152;
		sens_reg = 16384;
		send_idle_pct = 15;
		recv_stall_pct = 86;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sweep at the reset register values
		foreach (directed_rows[i]) begin
			send_sample(directed_rows[i].thr, directed_rows[i].trn, directed_rows[i].known,
				directed_rows[i].drv);
		end
		in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(negedge clk);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct = (phase < 2) ? 15 : ((phase < 4) ? 86 : 0);
			recv_stall_pct = (phase < 2) ? 86 : ((phase < 4) ? 15 : 0);
			case (phase)
				1: begin
					program_regs(0, 16384, 131071, 65535);
				end
				2: begin
					program_regs(16384, 0, 0, 0);
				end
				3, 5: begin
					program_regs($urandom_range(16384), $urandom_range(16384),
						$urandom_range(131071), $urandom_range(65535));
				end
				4: begin
					program_regs(328, 328, 49152, 16384);
				end
				default: begin
				end
			endcase
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				pick_pair(thr, trn);
				send_sample(thr, trn, 1'b0, none);
			end
			in_valid <= 1'b0;
			while (pending_drive.size() != 0) @(negedge clk);
		end

		repeat (20) @(negedge clk);
		$display("checked %0d drive results from %0d transactions", results_seen, sent_count);
		$display("over %0d register settings with sender and receiver idling swapped, then none",
			NUM_PHASES);
		if (mismatches == 0 && pending_drive.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== curvature_drive_mixer.f =====
hdl/cdm_pkg.sv
hdl/cdm_front.sv
hdl/cdm_queue.sv
hdl/cdm_back.sv
hdl/curvature_drive_mixer.sv
dv/tb_curvature_drive_mixer.sv
